[hw/rtl/pdc_pkg.sv]
// pdc_pkg: shared widths, register indexes, reset values and control types
// for the PID pump duty controller. No dependencies.
package pdc_pkg;

    localparam int MEAS_W     = 12;
    localparam int DT_W       = 8;
    localparam int ERR_W      = 13;
    localparam int DIFF_W     = 14;
    localparam int GAIN_W     = 16;
    localparam int INTEG_W    = 32;
    localparam int EDPROD_W   = 21;   // err * elapsed
    localparam int DPROD_W    = 30;   // gain_d * error change
    localparam int PROD_W     = INTEG_W + GAIN_W;
    localparam int ACC_W      = 50;
    localparam int FRAC_W     = 8;
    localparam int DUTY_W     = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CEILING  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FLOOR    = 3'd6;

    localparam logic [MEAS_W-1:0]        RST_SETPOINT = '0;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_P   = 16'sd256;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I   = '0;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D   = '0;
    localparam logic [MEAS_W-1:0]        RST_DEADBAND = '0;
    localparam logic [DUTY_W-1:0]        RST_CEILING  = 7'd100;
    localparam logic [DUTY_W-1:0]        RST_FLOOR    = 7'd70;

    typedef struct packed {
        logic [MEAS_W-1:0]        setpoint;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [MEAS_W-1:0]        deadband;
        logic [DUTY_W-1:0]        duty_ceiling;
        logic [DUTY_W-1:0]        duty_floor;
    } pdc_cfg_t;

    typedef enum logic [1:0] {
        MUL_ERR_DT,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_PROD,
        ACC_ADD_QUO
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ED,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUM,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     integ_en;
        acc_op_t  acc_op;
        logic     prev_upd;
        logic     div_start;
        logic     cmp_en;
        logic     out_load;
    } pdc_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_done;
    } pdc_stat_t;

endpackage

[hw/rtl/pdc_div.sv]
// pdc_div: iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero; a zero divisor gives zero. Uses pdc_pkg.
module pdc_div import pdc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [DPROD_W-1:0] dividend,
    input  logic [DT_W-1:0]           divisor,
    output logic                      done,
    output logic signed [DPROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DPROD_W + 1);

    logic [CNT_W-1:0]        cnt_reg;
    logic [DPROD_W-1:0]      quo_reg;
    logic [DT_W-1:0]         rem_reg;
    logic [DT_W-1:0]         dvs_reg;
    logic                    neg_reg;
    logic                    zero_reg;

    logic signed [DPROD_W-1:0] dvd_neg;
    logic [DPROD_W-1:0]        dvd_mag;
    logic [DT_W:0]             rem_sh;
    logic                      ge;
    logic [DT_W:0]             rem_new;
    logic signed [DPROD_W-1:0] quo_neg;

    assign dvd_neg = -dividend;
    assign dvd_mag = dividend[DPROD_W-1] ? dvd_neg : dividend;
    assign rem_sh  = {rem_reg, quo_reg[DPROD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
    assign quo_neg = -$signed(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(DPROD_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dvd_mag;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            neg_reg  <= dividend[DPROD_W-1];
            zero_reg <= divisor == '0;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DPROD_W-2:0], ge};
            rem_reg <= rem_new[DT_W-1:0];
        end
    end

    assign done     = cnt_reg == '0;
    assign quotient = zero_reg ? '0 : (neg_reg ? quo_neg : $signed(quo_reg));

endmodule

[hw/rtl/pdc_datapath.sv]
// pdc_datapath: error, integral and previous-error state, shared multiplier,
// accumulator, divider and the clamp/floor stage. Uses pdc_pkg and pdc_div.
module pdc_datapath import pdc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdc_cmd_t          cmd,
    input  pdc_cfg_t          cfg,
    input  logic [MEAS_W-1:0] meas,
    input  logic [DT_W-1:0]   dt,
    output logic              div_done,
    output logic [DUTY_W-1:0] duty,
    output logic              saturated
);

    logic [DT_W-1:0]            dt_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    prev_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       gt_reg;
    logic                       lt_reg;

    logic signed [ERR_W-1:0]    err_next;
    logic signed [ERR_W-1:0]    err_neg;
    logic [MEAS_W-1:0]          err_mag;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [INTEG_W-1:0]  mul_a;
    logic signed [GAIN_W-1:0]   mul_b;
    logic signed [DPROD_W-1:0]  quo;
    logic signed [ACC_W-1:0]    ceil_fx;
    logic signed [ACC_W-1:0]    floor_fx;

    assign err_next = $signed({1'b0, meas}) - $signed({1'b0, cfg.setpoint});
    assign err_neg  = -err_reg;
    assign err_mag  = err_reg[ERR_W-1] ? err_neg[MEAS_W-1:0] : err_reg[MEAS_W-1:0];

    assign integ_sum = (INTEG_W+1)'(integ_reg)
                     + (INTEG_W+1)'($signed(prod_reg[EDPROD_W-1:0]));

    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    assign diff = DIFF_W'(err_reg) - DIFF_W'(prev_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_ERR_DT: begin
                mul_a = INTEG_W'(err_reg);
                mul_b = $signed({{(GAIN_W-DT_W){1'b0}}, dt_reg});
            end
            MUL_P: begin
                mul_a = INTEG_W'(err_reg);
                mul_b = cfg.gain_p;
            end
            MUL_I: begin
                mul_a = integ_reg;
                mul_b = cfg.gain_i;
            end
            MUL_D: begin
                mul_a = INTEG_W'(diff);
                mul_b = cfg.gain_d;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end else begin
            if (cmd.integ_en && (err_mag > cfg.deadband)) begin
                integ_reg <= integ_next;
            end
            if (cmd.prev_upd) begin
                prev_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dt_reg  <= dt;
            err_reg <= err_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.acc_op)
            ACC_LOAD:     acc_reg <= ACC_W'(prod_reg);
            ACC_ADD_PROD: acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_ADD_QUO:  acc_reg <= acc_reg + ACC_W'(quo);
            default:      acc_reg <= acc_reg;
        endcase
        if (cmd.cmp_en) begin
            gt_reg <= acc_reg > ceil_fx;
            lt_reg <= acc_reg < floor_fx;
        end
    end

    pdc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ($signed(prod_reg[DPROD_W-1:0])),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign ceil_fx  = $signed(ACC_W'({cfg.duty_ceiling, {FRAC_W{1'b0}}}));
    assign floor_fx = $signed(ACC_W'({cfg.duty_floor, {FRAC_W{1'b0}}}));

    always_comb begin
        if (gt_reg) begin
            duty = (cfg.duty_ceiling < cfg.duty_floor) ? '0 : cfg.duty_ceiling;
        end else if (lt_reg) begin
            duty = '0;
        end else begin
            duty = acc_reg[FRAC_W+DUTY_W-1:FRAC_W];
        end
    end

    assign saturated = gt_reg;

endmodule

[hw/rtl/pdc_ctrl.sv]
// pdc_ctrl: sequencer for one request: multiply steps, integral update,
// divide, compare and result hand-off. Uses pdc_pkg.
module pdc_ctrl import pdc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  pdc_stat_t stat,
    output pdc_cmd_t  cmd,
    output logic      in_ready
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_ERR_DT;
        cmd.acc_op  = ACC_HOLD;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (stat.in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_ED;
                end
            end
            ST_MUL_ED: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR_DT;
                state_next  = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ_en = 1'b1;
                state_next   = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_D;
                cmd.acc_op   = ACC_ADD_PROD;
                cmd.prev_upd = 1'b1;
                state_next   = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.acc_op = ACC_ADD_QUO;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/pid_pump_duty_controller.sv]
// pid_pump_duty_controller: top level. Config registers, sequencer, datapath
// and the result register. Uses pdc_pkg, pdc_ctrl, pdc_datapath.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: measured_value, elapsed_seconds
//  m_        out  m_tvalid/m_tready  m_tdata: duty; m_tuser: saturated
//  cfg_      in   cfg_we             cfg_addr, cfg_wdata
//
// From acceptance to result a request makes four passes through the shared
// 32x16 multiplier with the integral update, then divider start and a 30-step
// bit-serial divide for the derivative term, then accumulate, compare and load.
// The next request is taken in the cycle after the result is loaded.
// A new request is taken once the previous result sits in the output register.
// A stalled output holds its result; the sequencer waits before loading the next.
// Reset (aresetn low, synchronous) clears integral and previous error and
// restores the config defaults.
module pid_pump_duty_controller import pdc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] measured_value, [19:12] elapsed_seconds
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [6:0] duty
    output logic                  m_tuser,   // [0] saturated
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    pdc_cfg_t          cfg_reg;
    pdc_cmd_t          cmd;
    pdc_stat_t         stat;
    logic              in_ready;
    logic              div_done;
    logic [DUTY_W-1:0] duty;
    logic              saturated;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [DUTY_W-1:0] m_duty_reg;
    logic              m_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint     <= RST_SETPOINT;
            cfg_reg.gain_p       <= RST_GAIN_P;
            cfg_reg.gain_i       <= RST_GAIN_I;
            cfg_reg.gain_d       <= RST_GAIN_D;
            cfg_reg.deadband     <= RST_DEADBAND;
            cfg_reg.duty_ceiling <= RST_CEILING;
            cfg_reg.duty_floor   <= RST_FLOOR;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SETPOINT: cfg_reg.setpoint     <= cfg_wdata[MEAS_W-1:0];
                REG_GAIN_P:   cfg_reg.gain_p       <= $signed(cfg_wdata);
                REG_GAIN_I:   cfg_reg.gain_i       <= $signed(cfg_wdata);
                REG_GAIN_D:   cfg_reg.gain_d       <= $signed(cfg_wdata);
                REG_DEADBAND: cfg_reg.deadband     <= cfg_wdata[MEAS_W-1:0];
                REG_CEILING:  cfg_reg.duty_ceiling <= cfg_wdata[DUTY_W-1:0];
                REG_FLOOR:    cfg_reg.duty_floor   <= cfg_wdata[DUTY_W-1:0];
                default:      cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign stat.in_valid = s_tvalid;
    assign stat.out_free = !m_valid_reg || m_tready;
    assign stat.div_done = div_done;

    pdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    pdc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .meas      (s_tdata[MEAS_W-1:0]),
        .dt        (s_tdata[MEAS_W+DT_W-1:MEAS_W]),
        .div_done  (div_done),
        .duty      (duty),
        .saturated (saturated)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_duty_reg <= duty;
            m_sat_reg  <= saturated;
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_duty_reg);
    assign m_tuser  = m_sat_reg;

    // a saturated result is the ceiling, or zero when the ceiling is under the floor
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[DUTY_W-1:0] == cfg_reg.duty_ceiling) ||
                                (m_tdata[DUTY_W-1:0] == '0))
        else $error("saturated duty differs from ceiling");

    // an unclamped nonzero duty never lies below the floor
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && (m_tdata[DUTY_W-1:0] != '0)
            |-> m_tdata[DUTY_W-1:0] >= cfg_reg.duty_floor)
        else $error("duty below floor");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule
